>>> sv/tst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tst_pkg;

  // default sizes
  localparam int TOPIC_SLOTS_DEF    = 16;
  localparam int SUBS_PER_TOPIC_DEF = 16;
  localparam int KEY_BYTES_DEF      = 8;

  // field widths
  localparam int KEY_FIELD_W = 56;
  localparam int ID_W        = 10;
  localparam int RCNT_W      = 5;

  // request actions
  localparam logic [1:0] ACT_SUBSCRIBE   = 2'd0;
  localparam logic [1:0] ACT_UNSUBSCRIBE = 2'd1;
  localparam logic [1:0] ACT_PUBLISH     = 2'd2;
  localparam logic [1:0] ACT_REMOVE      = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ADDED      = 3'd0;
  localparam logic [2:0] ST_ALREADY    = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL = 3'd2;
  localparam logic [2:0] ST_LIST_FULL  = 3'd3;
  localparam logic [2:0] ST_MISSING    = 3'd4;
  localparam logic [2:0] ST_NOT_SUB    = 3'd5;
  localparam logic [2:0] ST_DONE       = 3'd6;

  typedef struct packed {
    logic [1:0]             action;
    logic [ID_W-1:0]        client_id;
    logic [KEY_FIELD_W-1:0] topic_key;
  } req_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              delivery_valid;
    logic [ID_W-1:0]   subscriber_id;
    logic [RCNT_W-1:0] recipient_count;
    logic              last;
  } rsp_word_t;

endpackage
`default_nettype wire

>>> sv/topic_subscription_table.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | valid     | ready     | word
// request | req_valid | req_ready | req (tst_pkg::req_word_t)
// result  | rsp_valid | rsp_ready | rsp (tst_pkg::rsp_word_t)
//
// One request at a time; every memory read has an address state, then a check state.
// Steps per request: accept, compare each topic key, read the count, scan each list
// entry, move the last entry into the hole for a removal, create a topic, append,
// step to each topic in a remove sweep, load the result. Remove sweeps every
// topic in use. Publish emits one word per list entry.
// Reset clears the topic count and control; stores need no clearing pass.
// A full result register stalls the sequencer; a new request is taken while the
// last result still waits.
module topic_subscription_table #(
  parameter int TOPIC_SLOTS    = tst_pkg::TOPIC_SLOTS_DEF,
  parameter int SUBS_PER_TOPIC = tst_pkg::SUBS_PER_TOPIC_DEF,
  parameter int KEY_BYTES      = tst_pkg::KEY_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire tst_pkg::req_word_t req,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output tst_pkg::rsp_word_t      rsp
);

  localparam int KW = ((KEY_BYTES - 1) * 8 < tst_pkg::KEY_FIELD_W) ?
                      (KEY_BYTES - 1) * 8 : tst_pkg::KEY_FIELD_W;
  localparam int TW = (TOPIC_SLOTS > 1) ? $clog2(TOPIC_SLOTS) : 1;
  localparam int UW = $clog2(TOPIC_SLOTS + 1);
  localparam int JW = (SUBS_PER_TOPIC > 1) ? $clog2(SUBS_PER_TOPIC) : 1;
  localparam int CW = $clog2(SUBS_PER_TOPIC + 1);
  localparam int IDS_DEPTH = TOPIC_SLOTS * SUBS_PER_TOPIC;
  localparam int AW = (IDS_DEPTH > 1) ? $clog2(IDS_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_T_RD, S_T_CHK, S_MISS, S_C_RD, S_C_CHK,
    S_L_RD, S_L_CHK, S_M_RD, S_M_WR, S_APPEND, S_NEXT, S_EMIT
  } state_t;

  state_t                 state;
  logic [1:0]             act;
  logic [tst_pkg::ID_W-1:0] cid;
  logic [KW-1:0]          key;
  logic [TW-1:0]          tcur;
  logic [JW-1:0]          j;
  logic [CW-1:0]          n;
  logic [UW-1:0]          in_use;
  logic [2:0]             res_status;

  logic                   key_we;
  logic [TW-1:0]          key_waddr;
  logic [KW-1:0]          key_rdata;
  logic                   cnt_we;
  logic [TW-1:0]          cnt_waddr;
  logic [CW-1:0]          cnt_wdata;
  logic [CW-1:0]          cnt_rdata;
  logic                   ids_we;
  logic [AW-1:0]          ids_waddr;
  logic [tst_pkg::ID_W-1:0] ids_wdata;
  logic [AW-1:0]          ids_raddr;
  logic [tst_pkg::ID_W-1:0] ids_rdata;
  logic [AW-1:0]          base;
  logic                   slot_free;
  logic                   topic_last;
  logic                   entry_last;
  logic                   can_create;
  logic                   rsp_load;

  assign slot_free  = !rsp_valid || rsp_ready;
  assign topic_last = (UW'(tcur) + UW'(1)) >= in_use;
  assign entry_last = (CW'(j) + CW'(1)) == n;
  assign can_create = in_use != UW'(TOPIC_SLOTS);
  assign req_ready  = (state == S_IDLE);
  assign base       = AW'(tcur) * AW'(SUBS_PER_TOPIC);
  // result register loads a new word this cycle
  assign rsp_load   = slot_free && ((state == S_EMIT) ||
                      ((state == S_L_CHK) && (act == tst_pkg::ACT_PUBLISH)));

  // memory ports
  always_comb begin
    key_we    = (state == S_MISS) && (act == tst_pkg::ACT_SUBSCRIBE) && can_create;
    key_waddr = TW'(in_use);
    cnt_we    = key_we;
    cnt_waddr = TW'(in_use);
    cnt_wdata = '0;
    ids_we    = 1'b0;
    ids_waddr = base + AW'(j);
    ids_wdata = ids_rdata;
    ids_raddr = base + AW'(j);
    unique case (state)
      S_M_RD: begin
        ids_raddr = base + AW'(JW'(n - CW'(1)));
      end
      S_M_WR: begin
        ids_we    = 1'b1;
        cnt_we    = 1'b1;
        cnt_waddr = tcur;
        cnt_wdata = n - CW'(1);
      end
      S_APPEND: begin
        ids_we    = 1'b1;
        ids_waddr = base + AW'(JW'(n));
        ids_wdata = cid;
        cnt_we    = 1'b1;
        cnt_waddr = tcur;
        cnt_wdata = n + CW'(1);
      end
      default: begin
      end
    endcase
  end

  tst_ram #(.DEPTH(TOPIC_SLOTS), .WIDTH(KW)) u_keys (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key),
    .raddr(tcur), .rdata(key_rdata)
  );

  tst_ram #(.DEPTH(TOPIC_SLOTS), .WIDTH(CW)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(tcur), .rdata(cnt_rdata)
  );

  tst_ram #(.DEPTH(IDS_DEPTH), .WIDTH(tst_pkg::ID_W)) u_ids (
    .clk(clk), .we(ids_we), .waddr(ids_waddr), .wdata(ids_wdata),
    .raddr(ids_raddr), .rdata(ids_rdata)
  );

  // request sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_use    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            act  <= req.action;
            cid  <= req.client_id;
            key  <= req.topic_key[KW-1:0];
            tcur <= '0;
            if (req.action == tst_pkg::ACT_REMOVE) begin
              res_status <= tst_pkg::ST_DONE;
              state      <= (in_use == '0) ? S_EMIT : S_C_RD;
            end else begin
              state <= (in_use == '0) ? S_MISS : S_T_RD;
            end
          end
        end
        S_T_RD: begin
          state <= S_T_CHK;
        end
        // compare one stored key
        S_T_CHK: begin
          if (key_rdata == key) begin
            state <= S_C_RD;
          end else if (topic_last) begin
            state <= S_MISS;
          end else begin
            tcur  <= tcur + TW'(1);
            state <= S_T_RD;
          end
        end
        // topic absent: create it for subscribe if the table has room, else report
        S_MISS: begin
          if (act != tst_pkg::ACT_SUBSCRIBE) begin
            res_status <= tst_pkg::ST_MISSING;
            state      <= S_EMIT;
          end else if (!can_create) begin
            res_status <= tst_pkg::ST_TABLE_FULL;
            state      <= S_EMIT;
          end else begin
            tcur   <= TW'(in_use);
            in_use <= in_use + UW'(1);
            n      <= '0;
            state  <= S_APPEND;
          end
        end
        S_C_RD: begin
          state <= S_C_CHK;
        end
        // list length known
        S_C_CHK: begin
          n <= cnt_rdata;
          j <= '0;
          if (cnt_rdata != '0) begin
            state <= S_L_RD;
          end else begin
            case (act)
              tst_pkg::ACT_SUBSCRIBE: state <= S_APPEND;
              tst_pkg::ACT_UNSUBSCRIBE: begin
                res_status <= tst_pkg::ST_NOT_SUB;
                state      <= S_EMIT;
              end
              tst_pkg::ACT_PUBLISH: begin
                res_status <= tst_pkg::ST_DONE;
                state      <= S_EMIT;
              end
              default: state <= S_NEXT;
            endcase
          end
        end
        S_L_RD: begin
          state <= S_L_CHK;
        end
        // one list entry
        S_L_CHK: begin
          if (act == tst_pkg::ACT_PUBLISH) begin
            if (slot_free) begin
              rsp_valid           <= 1'b1;
              rsp.status          <= tst_pkg::ST_DONE;
              rsp.delivery_valid  <= 1'b1;
              rsp.subscriber_id   <= ids_rdata;
              rsp.recipient_count <= tst_pkg::RCNT_W'(n);
              rsp.last            <= entry_last;
              if (entry_last) begin
                state <= S_IDLE;
              end else begin
                j     <= j + JW'(1);
                state <= S_L_RD;
              end
            end
          end else if (ids_rdata == cid) begin
            if (act == tst_pkg::ACT_SUBSCRIBE) begin
              res_status <= tst_pkg::ST_ALREADY;
              state      <= S_EMIT;
            end else begin
              state <= S_M_RD;
            end
          end else if (entry_last) begin
            case (act)
              tst_pkg::ACT_SUBSCRIBE: begin
                if (n >= CW'(SUBS_PER_TOPIC)) begin
                  res_status <= tst_pkg::ST_LIST_FULL;
                  state      <= S_EMIT;
                end else begin
                  state <= S_APPEND;
                end
              end
              tst_pkg::ACT_UNSUBSCRIBE: begin
                res_status <= tst_pkg::ST_NOT_SUB;
                state      <= S_EMIT;
              end
              default: state <= S_NEXT;
            endcase
          end else begin
            j     <= j + JW'(1);
            state <= S_L_RD;
          end
        end
        S_M_RD: begin
          state <= S_M_WR;
        end
        // last entry moved into the hole
        S_M_WR: begin
          if (act == tst_pkg::ACT_REMOVE) begin
            state <= S_NEXT;
          end else begin
            res_status <= tst_pkg::ST_DONE;
            state      <= S_EMIT;
          end
        end
        S_APPEND: begin
          res_status <= tst_pkg::ST_ADDED;
          state      <= S_EMIT;
        end
        // remove sweep: next topic
        S_NEXT: begin
          if (topic_last) begin
            res_status <= tst_pkg::ST_DONE;
            state      <= S_EMIT;
          end else begin
            tcur  <= tcur + TW'(1);
            state <= S_C_RD;
          end
        end
        // single result word
        S_EMIT: begin
          if (slot_free) begin
            rsp_valid           <= 1'b1;
            rsp.status          <= res_status;
            rsp.delivery_valid  <= 1'b0;
            rsp.subscriber_id   <= '0;
            rsp.recipient_count <= '0;
            rsp.last            <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/tst_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tst_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> verif/tb_topic_subscription_table.sv
`timescale 1ns / 1ps
module tb_topic_subscription_table;

  localparam int NT = tst_pkg::TOPIC_SLOTS_DEF;
  localparam int NS = tst_pkg::SUBS_PER_TOPIC_DEF;
  localparam int KW = (tst_pkg::KEY_BYTES_DEF - 1) * 8;
  localparam int IW = tst_pkg::ID_W;
  localparam int FW = tst_pkg::KEY_FIELD_W;
  localparam int WATCHDOG_LIMIT = 20000;

  // membership table model and queue of expected result words
  class membership_board;
    logic [KW-1:0]      keys[NT];
    int                 n_topics;
    int                 counts[NT];
    logic [IW-1:0]      ids[NT][NS];
    tst_pkg::rsp_word_t pending[$];
    int                 errors;

    function void clear();
      n_topics = 0;
      foreach (counts[i]) counts[i] = 0;
      pending.delete();
      errors = 0;
    endfunction

    function int find_topic(logic [KW-1:0] k);
      for (int i = 0; i < n_topics; i++) if (keys[i] == k) return i;
      return -1;
    endfunction

    function bit drop(int t, logic [IW-1:0] id);
      for (int j = 0; j < counts[t]; j++) begin
        if (ids[t][j] == id) begin
          ids[t][j] = ids[t][counts[t]-1];
          counts[t]--;
          return 1;
        end
      end
      return 0;
    endfunction

    function void push(logic [2:0] st, bit dv, logic [IW-1:0] id, int cnt, bit lst);
      tst_pkg::rsp_word_t w;
      w.status = st;
      w.delivery_valid = dv;
      w.subscriber_id = id;
      w.recipient_count = cnt[tst_pkg::RCNT_W-1:0];
      w.last = lst;
      pending.push_back(w);
    endfunction

    // note an accepted request and queue its results
    function void note_request(tst_pkg::req_word_t r);
      logic [KW-1:0] k;
      int t;
      bit hit;
      k = r.topic_key[KW-1:0];
      t = find_topic(k);
      case (r.action)
        tst_pkg::ACT_SUBSCRIBE: begin
          if (t < 0 && n_topics >= NT) begin
            push(tst_pkg::ST_TABLE_FULL, 0, 0, 0, 1);
            return;
          end
          if (t < 0) begin
            t = n_topics;
            keys[t] = k;
            counts[t] = 0;
            n_topics++;
          end
          hit = 0;
          for (int j = 0; j < counts[t]; j++) if (ids[t][j] == r.client_id) hit = 1;
          if (hit) push(tst_pkg::ST_ALREADY, 0, 0, 0, 1);
          else if (counts[t] >= NS) push(tst_pkg::ST_LIST_FULL, 0, 0, 0, 1);
          else begin
            ids[t][counts[t]] = r.client_id;
            counts[t]++;
            push(tst_pkg::ST_ADDED, 0, 0, 0, 1);
          end
        end
        tst_pkg::ACT_UNSUBSCRIBE: begin
          if (t < 0) push(tst_pkg::ST_MISSING, 0, 0, 0, 1);
          else if (drop(t, r.client_id)) push(tst_pkg::ST_DONE, 0, 0, 0, 1);
          else push(tst_pkg::ST_NOT_SUB, 0, 0, 0, 1);
        end
        tst_pkg::ACT_PUBLISH: begin
          if (t < 0) push(tst_pkg::ST_MISSING, 0, 0, 0, 1);
          else if (counts[t] == 0) push(tst_pkg::ST_DONE, 0, 0, 0, 1);
          else
            for (int j = 0; j < counts[t]; j++)
              push(tst_pkg::ST_DONE, 1, ids[t][j], counts[t], j == counts[t] - 1);
        end
        default: begin
          for (int i = 0; i < n_topics; i++) void'(drop(i, r.client_id));
          push(tst_pkg::ST_DONE, 0, 0, 0, 1);
        end
      endcase
    endfunction

    function void check_result(tst_pkg::rsp_word_t got);
      tst_pkg::rsp_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.delivery_valid !== want.delivery_valid ||
          got.subscriber_id !== want.subscriber_id ||
          got.recipient_count !== want.recipient_count || got.last !== want.last) begin
        $display("%0t: mismatch, expected %h, actual %h", $realtime, want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               req_valid = 0;
  logic               req_ready;
  tst_pkg::req_word_t req = '0;
  logic               rsp_valid;
  logic               rsp_ready = 0;
  tst_pkg::rsp_word_t rsp;

  membership_board board = new();
  bit  quiet = 0;       // no idling on either side
  bit  hold_off = 0;    // receiver long stall
  int  idle_cycles = 0;

  topic_subscription_table i_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // sample accepted words at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) board.note_request(req);
      if (rsp_valid && rsp_ready) board.check_result(rsp);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // result side ready, with random stalls
  always @(negedge clk) begin
    if (rst || hold_off) rsp_ready <= 0;
    else rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL topic_subscription_table");
      $finish;
    end
  end

  // valid stays high after an accept until the next idle gap or pause
  task automatic send_word(logic [1:0] act, logic [IW-1:0] id, logic [FW-1:0] k);
    while (!quiet && $urandom_range(99) < 34) begin
      req_valid <= 0;
      @(negedge clk);
    end
    req_valid <= 1;
    req.action <= act;
    req.client_id <= id;
    req.topic_key <= k;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [FW-1:0] pick_key(int pool);
    logic [FW-1:0] k;
    k = FW'({$urandom, $urandom});
    k[KW-1:0] = 56'h1000 + $urandom_range(pool - 1);
    if ($urandom_range(3) == 0) k = FW'({$urandom, $urandom});
    return k;
  endfunction

  initial begin
    logic [FW-1:0] hot;
    board.clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: missing topic, empty publish, extremes, duplicates
    send_word(tst_pkg::ACT_PUBLISH, 0, '0);
    send_word(tst_pkg::ACT_UNSUBSCRIBE, 5, '0);
    send_word(tst_pkg::ACT_SUBSCRIBE, 10'h3ff, '1);
    send_word(tst_pkg::ACT_SUBSCRIBE, 10'h3ff, {KW{1'b1}});
    send_word(tst_pkg::ACT_SUBSCRIBE, 0, '0);
    send_word(tst_pkg::ACT_PUBLISH, 0, '1);
    send_word(tst_pkg::ACT_UNSUBSCRIBE, 7, '1);
    send_word(tst_pkg::ACT_UNSUBSCRIBE, 10'h3ff, '1);
    send_word(tst_pkg::ACT_PUBLISH, 0, '1);
    // fill one list past full
    for (int i = 0; i < NS + 1; i++)
      send_word(tst_pkg::ACT_SUBSCRIBE, IW'(10'h200 + i), 56'h55);
    send_word(tst_pkg::ACT_PUBLISH, 0, 56'h55);
    send_word(tst_pkg::ACT_REMOVE, 10'h203, '0);
    send_word(tst_pkg::ACT_PUBLISH, 0, 56'h55);
    wait_drained();

    // receiver holds off while requests keep coming
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) send_word(tst_pkg::ACT_PUBLISH, 0, 56'h55);
    join
    wait_drained();

    // fill the topic table past full, then subscribe a new key
    for (int i = 0; i < NT; i++)
      send_word(tst_pkg::ACT_SUBSCRIBE, IW'(i), 56'h9000 + i);
    send_word(tst_pkg::ACT_SUBSCRIBE, 1, 56'hABCDEF);
    send_word(tst_pkg::ACT_UNSUBSCRIBE, 1, 56'hABCDEF);
    wait_drained();

    // random traffic on a small key pool; a quiet stretch in the middle
    for (int i = 0; i < 50; i++) begin
      quiet = (i >= 20 && i < 35);
      hot = pick_key(6);
      if ($urandom_range(1)) hot[KW-1:0] = 56'h9000 + $urandom_range(NT - 1);
      send_word(2'($urandom_range(3)),
                $urandom_range(1) ? IW'($urandom_range(20)) : IW'($urandom), hot);
    end
    quiet = 0;
    req_valid <= 0;

    while (board.pending.size() != 0 && idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    repeat (100) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASS topic_subscription_table");
    else
      $display("FAIL topic_subscription_table");
    $finish;
  end
endmodule
